// ===== sv/gregorian_date_offset_and_difference_unit_macros.svh =====
// Assertion macros for the Gregorian date offset and difference unit.
// Included by the checker module; depends on nothing else.
`ifndef GREGORIAN_DATE_OFFSET_AND_DIFFERENCE_UNIT_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_AND_DIFFERENCE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDO_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("gdo: property failed in the same cycle");

// The consequent must have held a fixed number of cycles earlier.
`define GDO_ASSERT_PAST(label, clk, rst_n, cond, prop, n) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> $past((prop), n)) \
		else $error("gdo: expected earlier cause not found");

// The consequent must hold a fixed number of cycles later.
`define GDO_ASSERT_LATER(label, clk, rst_n, cond, prop, n) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##n (prop)) \
		else $error("gdo: expected later effect not found");

`endif

// ===== sv/gdo_pkg.sv =====
// Shared types, constants and tables of the Gregorian date offset and difference unit.
// Depends on nothing; used by every module of the unit.
package gdo_pkg;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	// Stages inside the day-count to date converter, and the whole unit.
	localparam int SPLIT_STAGES = 11;
	localparam int LATENCY      = 15;

	localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
	localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [8:0]  YEAR_BIAS     = 9'd400;

	// Reciprocals: ceil(2^16/25), floor(2^22/146097), floor(2^16/365), floor(2^18/365).
	localparam logic [11:0] RECIP_25      = 12'd2622;
	localparam logic [4:0]  RECIP_ERA     = 5'd28;
	localparam logic [7:0]  RECIP_365_Q16 = 8'd179;
	localparam logic [9:0]  RECIP_365_Q18 = 10'd718;

	// Biased day counts of 0000-01-01 and 10000-01-01 (count 0 is 0400 years before 0000-03-01).
	localparam logic signed [24:0] U_MIN   = 25'sd146037;
	localparam logic signed [24:0] U_LIMIT = 25'sd3798462;

	localparam logic signed [22:0] DIFF_MAX = 23'sh3FFFFF;
	localparam logic signed [22:0] DIFF_MIN = 23'sh400000;

	// Day of the year, counted from 1 March, on which a March-based month starts.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/gregorian_date_offset_and_difference_unit.sv =====
// Top level of the Gregorian date offset and difference unit.
// Depends on gdo_pkg, gdo_day_count and gdo_date_split.
//
// Channel | Handshake               | Beat contents
// command | start && !busy          | from_year/month/day, to_year/month/day, offset_days
// result  | done, one-cycle strobe  | day_difference, shifted_year/month/day, shift_out_of_range
//
// Every beat passes through the 15-stage pipeline from accept to done.
// A new command beat is taken in every cycle, so busy stays low.
// Reset clears only the valid bits; data registers hold whatever they hold.
// The receiver cannot stall: each result beat is presented once, for one cycle.
module gregorian_date_offset_and_difference_unit import gdo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [13:0]        from_year,
	input  logic [3:0]         from_month,
	input  logic [4:0]         from_day,
	input  logic [13:0]        to_year,
	input  logic [3:0]         to_month,
	input  logic [4:0]         to_day,
	input  logic signed [22:0] offset_days,
	output logic               done,
	output logic signed [22:0] day_difference,
	output logic [13:0]        shifted_year,
	output logic [3:0]         shifted_month,
	output logic [4:0]         shifted_day,
	output logic               shift_out_of_range
);

	date_t       from_date;
	date_t       to_date;
	date_t       split_date;
	logic [22:0] count_from;
	logic [22:0] count_to;
	logic        split_valid;
	logic [23:0] diff_full;
	logic signed [24:0] u;

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic signed [22:0] off_s1;
	logic signed [22:0] off_s2;
	logic signed [22:0] diff_s3;
	logic               under_s3;
	logic               over_s3;
	logic [21:0]        count_s3;

	logic signed [22:0] diff_dly_q  [SPLIT_STAGES];
	logic               under_dly_q [SPLIT_STAGES];
	logic               over_dly_q  [SPLIT_STAGES];

	logic               valid_s15;
	logic signed [22:0] diff_s15;
	logic [13:0]        year_s15;
	logic [3:0]         month_s15;
	logic [4:0]         day_s15;
	logic               flag_s15;

	assign busy      = 1'b0;
	assign from_date = {from_year, from_month, from_day};
	assign to_date   = {to_year, to_month, to_day};

	gdo_day_count u_count_from (
		.clk   (clk),
		.date  (from_date),
		.count (count_from)
	);

	gdo_day_count u_count_to (
		.clk   (clk),
		.date  (to_date),
		.count (count_to)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s15 <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s15 <= split_valid;
		end
	end

	// Both counts carry the same bias, so the difference needs no correction.
	assign diff_full = {1'b0, count_to} - {1'b0, count_from};
	assign u = $signed({2'b0, count_from}) + $signed({{2{off_s2[22]}}, off_s2});

	always_ff @(posedge clk) begin
		off_s1 <= offset_days;
		off_s2 <= off_s1;

		if (diff_full[23] != diff_full[22]) begin
			diff_s3 <= diff_full[23] ? DIFF_MIN : DIFF_MAX;
		end else begin
			diff_s3 <= $signed(diff_full[22:0]);
		end
		under_s3 <= (u < U_MIN);
		over_s3  <= (u >= U_LIMIT);
		count_s3 <= u[21:0];
	end

	gdo_date_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.count     (count_s3),
		.out_valid (split_valid),
		.date      (split_date)
	);

	// The difference and the range flags wait here while the date is rebuilt.
	always_ff @(posedge clk) begin
		diff_dly_q[0]  <= diff_s3;
		under_dly_q[0] <= under_s3;
		over_dly_q[0]  <= over_s3;
		for (int i = 1; i < SPLIT_STAGES; i++) begin
			diff_dly_q[i]  <= diff_dly_q[i-1];
			under_dly_q[i] <= under_dly_q[i-1];
			over_dly_q[i]  <= over_dly_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		diff_s15 <= diff_dly_q[SPLIT_STAGES-1];
		if (under_dly_q[SPLIT_STAGES-1]) begin
			year_s15  <= 14'd0;
			month_s15 <= 4'd1;
			day_s15   <= 5'd1;
			flag_s15  <= 1'b1;
		end else if (over_dly_q[SPLIT_STAGES-1]) begin
			year_s15  <= 14'd9999;
			month_s15 <= 4'd12;
			day_s15   <= 5'd31;
			flag_s15  <= 1'b1;
		end else begin
			year_s15  <= split_date.year;
			month_s15 <= split_date.month;
			day_s15   <= split_date.day;
			flag_s15  <= 1'b0;
		end
	end

	assign done               = valid_s15;
	assign day_difference     = diff_s15;
	assign shifted_year       = year_s15;
	assign shifted_month      = month_s15;
	assign shifted_day        = day_s15;
	assign shift_out_of_range = flag_s15;

endmodule

// ===== sv/gdo_day_count.sv =====
// Two-stage conversion of one year/month/day into a biased day count.
// Depends on gdo_pkg for the date type, constants and month table.
module gdo_day_count import gdo_pkg::*; (
	input  logic        clk,
	input  date_t       date,
	output logic [22:0] count
);

	logic        early;
	logic [14:0] yb;
	logic [3:0]  mp;
	logic [22:0] p365;
	logic [23:0] prod100;
	logic [21:0] prod400;
	logic [8:0]  md;
	logic [23:0] sum;

	logic [22:0] p365_s1;
	logic [12:0] q4_s1;
	logic [7:0]  q100_s1;
	logic [5:0]  q400_s1;
	logic [8:0]  md_s1;
	logic [22:0] count_s2;

	// January and February belong to the previous March-based year; the year is
	// biased by 400 so that the leap-day terms never see a negative value.
	assign early   = (date.month <= 4'd2);
	assign yb      = {1'b0, date.year} + {6'b0, YEAR_BIAS} - {14'b0, early};
	assign mp      = early ? (date.month + 4'd9) : (date.month - 4'd3);
	assign p365    = {8'b0, yb} * {14'b0, DAYS_PER_YEAR};
	assign prod100 = {11'b0, yb[14:2]} * {12'b0, RECIP_25};
	assign prod400 = {11'b0, yb[14:4]} * {10'b0, RECIP_25};
	assign md      = month_start(mp) + {4'b0, date.day};

	always_ff @(posedge clk) begin
		p365_s1 <= p365;
		q4_s1   <= yb[14:2];
		q100_s1 <= prod100[23:16];
		q400_s1 <= prod400[21:16];
		md_s1   <= md;
	end

	assign sum = {1'b0, p365_s1} + {11'b0, q4_s1} - {16'b0, q100_s1}
		+ {18'b0, q400_s1} + {15'b0, md_s1} - 24'd1;

	always_ff @(posedge clk) begin
		count_s2 <= sum[22:0];
	end

	assign count = count_s2;

endmodule

// ===== sv/gdo_date_split.sv =====
// Pipelined conversion of a biased day count back into year, month and day.
// Depends on gdo_pkg; reciprocal multiplies with one correction replace the divisions.
module gdo_date_split import gdo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [21:0] count,
	output logic        out_valid,
	output date_t       date
);

	localparam logic [17:0] CENT1 = 18'd36524;
	localparam logic [17:0] CENT2 = 18'd73048;
	localparam logic [17:0] CENT3 = 18'd109572;

	logic [SPLIT_STAGES-1:0] stage_valid_q;

	logic [26:0] eprod;
	logic [22:0] eback;
	logic [22:0] rem_full;
	logic        rem_ge;
	logic [18:0] rem_adj;
	logic [22:0] c1prod;
	logic [15:0] r1;
	logic [17:0] t_full;
	logic [27:0] yeprod;
	logic [17:0] r2;
	logic [1:0]  cy;
	logic [17:0] doy_full;
	logic [3:0]  mp_cnt;
	logic [8:0]  day_full;
	logic [15:0] year_full;

	logic [4:0]  era_est_s1;
	logic [21:0] count_s1;
	logic [18:0] rem_s2;
	logic [4:0]  era_est_s2;
	logic [17:0] doe_s3;
	logic [4:0]  era_s3;
	logic [6:0]  c1_s4;
	logic [2:0]  cent_s4;
	logic        last_s4;
	logic [17:0] doe_s4;
	logic [4:0]  era_s4;
	logic [6:0]  q1460_s5;
	logic [2:0]  cent_s5;
	logic        last_s5;
	logic [17:0] doe_s5;
	logic [4:0]  era_s5;
	logic [17:0] t_s6;
	logic [17:0] doe_s6;
	logic [4:0]  era_s6;
	logic [8:0]  ye_s7;
	logic [17:0] t_s7;
	logic [17:0] doe_s7;
	logic [4:0]  era_s7;
	logic [8:0]  yoe_s8;
	logic [17:0] doe_s8;
	logic [4:0]  era_s8;
	logic [8:0]  doy_s9;
	logic [8:0]  yoe_s9;
	logic [4:0]  era_s9;
	logic [3:0]  mp_s10;
	logic [8:0]  doy_s10;
	logic [8:0]  yoe_s10;
	logic [4:0]  era_s10;
	logic [13:0] year_s11;
	logic [3:0]  month_s11;
	logic [4:0]  day_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			stage_valid_q <= {stage_valid_q[SPLIT_STAGES-2:0], in_valid};
		end
	end

	// The era estimate is low by at most one; the next stages fix it.
	assign eprod    = {5'b0, count} * {22'b0, RECIP_ERA};
	assign eback    = {18'b0, era_est_s1} * {5'b0, DAYS_PER_ERA};
	assign rem_full = {1'b0, count_s1} - eback;
	assign rem_ge   = (rem_s2 >= {1'b0, DAYS_PER_ERA});
	assign rem_adj  = rem_s2 - {1'b0, DAYS_PER_ERA};

	// Leap-day terms of the year-of-era formula: doe/1460, doe/36524, doe/146096.
	assign c1prod = {7'b0, doe_s3[17:2]} * {15'b0, RECIP_365_Q16};
	assign r1     = doe_s4[17:2] - ({9'b0, c1_s4} * {7'b0, DAYS_PER_YEAR});
	assign t_full = doe_s5 - {11'b0, q1460_s5} + {15'b0, cent_s5} - {17'b0, last_s5};
	assign yeprod = {10'b0, t_s6} * {18'b0, RECIP_365_Q18};
	assign r2     = t_s7 - ({9'b0, ye_s7} * {9'b0, DAYS_PER_YEAR});

	always_comb begin
		cy = 2'd0;
		if (yoe_s8 >= 9'd100) cy = 2'd1;
		if (yoe_s8 >= 9'd200) cy = 2'd2;
		if (yoe_s8 >= 9'd300) cy = 2'd3;
	end

	assign doy_full = doe_s8 - ({9'b0, yoe_s8} * {9'b0, DAYS_PER_YEAR})
		- {11'b0, yoe_s8[8:2]} + {16'b0, cy};

	always_comb begin
		mp_cnt = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (month_start(4'(k)) <= doy_s9) mp_cnt = mp_cnt + 4'd1;
		end
	end

	assign day_full  = doy_s10 - month_start(mp_s10) + 9'd1;
	assign year_full = ({11'b0, era_s10} * {7'b0, YEAR_BIAS}) + {7'b0, yoe_s10}
		+ {15'b0, (mp_s10 >= 4'd10)} - {7'b0, YEAR_BIAS};

	always_ff @(posedge clk) begin
		era_est_s1 <= eprod[26:22];
		count_s1   <= count;

		rem_s2     <= rem_full[18:0];
		era_est_s2 <= era_est_s1;

		doe_s3 <= rem_ge ? rem_adj[17:0] : rem_s2[17:0];
		era_s3 <= era_est_s2 + {4'b0, rem_ge};

		c1_s4   <= c1prod[22:16];
		cent_s4 <= {2'b0, (doe_s3 >= CENT1)} + {2'b0, (doe_s3 >= CENT2)}
			+ {2'b0, (doe_s3 >= CENT3)} + {2'b0, (doe_s3 >= ERA_LAST_DAY)};
		last_s4 <= (doe_s3 == ERA_LAST_DAY);
		doe_s4  <= doe_s3;
		era_s4  <= era_s3;

		q1460_s5 <= c1_s4 + {6'b0, (r1 >= {7'b0, DAYS_PER_YEAR})};
		cent_s5  <= cent_s4;
		last_s5  <= last_s4;
		doe_s5   <= doe_s4;
		era_s5   <= era_s4;

		t_s6   <= t_full;
		doe_s6 <= doe_s5;
		era_s6 <= era_s5;

		ye_s7  <= yeprod[26:18];
		t_s7   <= t_s6;
		doe_s7 <= doe_s6;
		era_s7 <= era_s6;

		yoe_s8 <= ye_s7 + {8'b0, (r2 >= {9'b0, DAYS_PER_YEAR})};
		doe_s8 <= doe_s7;
		era_s8 <= era_s7;

		doy_s9 <= doy_full[8:0];
		yoe_s9 <= yoe_s8;
		era_s9 <= era_s8;

		mp_s10  <= mp_cnt;
		doy_s10 <= doy_s9;
		yoe_s10 <= yoe_s9;
		era_s10 <= era_s9;

		// March-based months ten and eleven are January and February of the next year.
		year_s11  <= year_full[13:0];
		month_s11 <= (mp_s10 < 4'd10) ? (mp_s10 + 4'd3) : (mp_s10 - 4'd9);
		day_s11   <= day_full[4:0];
	end

	assign out_valid  = stage_valid_q[SPLIT_STAGES-1];
	assign date.year  = year_s11;
	assign date.month = month_s11;
	assign date.day   = day_s11;

endmodule

// ===== sv/gdo_checker.sv =====
// Port-level checker for the Gregorian date offset and difference unit, with its bind.
// Depends on gdo_pkg and the assertion macro header.
`include "gregorian_date_offset_and_difference_unit_macros.svh"

module gdo_checker import gdo_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [13:0]        from_year,
	input logic [3:0]         from_month,
	input logic [4:0]         from_day,
	input logic [13:0]        to_year,
	input logic [3:0]         to_month,
	input logic [4:0]         to_day,
	input logic signed [22:0] offset_days,
	input logic               done,
	input logic signed [22:0] day_difference,
	input logic [13:0]        shifted_year,
	input logic [3:0]         shifted_month,
	input logic [4:0]         shifted_day,
	input logic               shift_out_of_range
);

	// Each accepted beat yields exactly one result beat after the fixed latency.
	`GDO_ASSERT_PAST(a_done_has_cause, clk, arst_n, done, start && !busy, LATENCY)
	`GDO_ASSERT_LATER(a_accept_gives_done, clk, arst_n, start && !busy, done, LATENCY)

	// A clamped result is one of the two end dates of the supported range.
	`GDO_ASSERT_IMPLY(a_clamp_value, clk, arst_n, done && shift_out_of_range, (shifted_year == 14'd0 && shifted_month == 4'd1 && shifted_day == 5'd1) || (shifted_year == 14'd9999 && shifted_month == 4'd12 && shifted_day == 5'd31))

	// An unclamped result always has a year up to 9999, a month from 1 to 12 and a day from 1 to 31.
	`GDO_ASSERT_IMPLY(a_shift_is_date, clk, arst_n, done && !shift_out_of_range, shifted_year <= 14'd9999 && shifted_month >= 4'd1 && shifted_month <= 4'd12 && shifted_day >= 5'd1 && shifted_day <= 5'd31)

endmodule

bind gregorian_date_offset_and_difference_unit gdo_checker u_checker (.*);

// ===== verif/tb_gregorian_date_offset_and_difference_unit.sv =====
// Self-checking testbench for gregorian_date_offset_and_difference_unit.
// Drives date-pair commands, predicts each result beat in place and compares them in order.
// Depends on gdo_pkg and the unit's RTL only.
module tb_gregorian_date_offset_and_difference_unit import gdo_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CYCLE_LIMIT  = 200000;
	localparam int     RANDOM_ITEMS = 750;
	localparam int     TAIL_ITEMS   = 80;
	localparam longint ERA_DAYS     = 146097;
	localparam longint EPOCH_BIAS   = 719468;
	localparam longint DIFF_HI      = 4194303;
	localparam longint DIFF_LO      = -4194304;

	typedef struct {
		date_t              from_date;
		date_t              to_date;
		logic signed [22:0] offset;
		bit                 drain_first;
	} date_cmd_t;

	typedef struct {
		logic signed [22:0] difference;
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic               out_of_range;
	} conversion_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [13:0]        from_year = '0;
	logic [3:0]         from_month = '0;
	logic [4:0]         from_day = '0;
	logic [13:0]        to_year = '0;
	logic [3:0]         to_month = '0;
	logic [4:0]         to_day = '0;
	logic signed [22:0] offset_days = '0;
	logic               done;
	logic signed [22:0] day_difference;
	logic [13:0]        shifted_year;
	logic [3:0]         shifted_month;
	logic [4:0]         shifted_day;
	logic               shift_out_of_range;

	date_cmd_t   date_cmd_q[$];
	conversion_t conversion_q[$];
	date_cmd_t   driven_cmd;
	int          gap_left = 0;
	int          failures = 0;
	int          cycle_count = 0;

	gregorian_date_offset_and_difference_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.from_year(from_year),
		.from_month(from_month),
		.from_day(from_day),
		.to_year(to_year),
		.to_month(to_month),
		.to_day(to_day),
		.offset_days(offset_days),
		.done(done),
		.day_difference(day_difference),
		.shifted_year(shifted_year),
		.shifted_month(shifted_month),
		.shifted_day(shifted_day),
		.shift_out_of_range(shift_out_of_range)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if (a % b < 0) begin
			q -= 1;
		end
		return q;
	endfunction

	// Years start on 1 March, so January and February belong to the year before.
	function automatic longint day_serial(longint y, longint m, longint d);
		longint yy, mp, era, yoe, doy, doe;
		yy = y;
		if (m <= 2) begin
			yy = y - 1;
			mp = m + 9;
		end else begin
			mp = m - 3;
		end
		era = floor_quot(yy, 400);
		yoe = yy - era * 400;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * ERA_DAYS + doe - EPOCH_BIAS;
	endfunction

	function automatic void date_of_serial(input longint z, output longint y,
			output longint m, output longint d);
		longint zz, era, doe, yoe, doy, mp;
		zz = z + EPOCH_BIAS;
		era = floor_quot(zz, ERA_DAYS);
		doe = zz - era * ERA_DAYS;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		y = yoe + era * 400;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		if (m <= 2) begin
			y += 1;
		end
	endfunction

	function automatic conversion_t convert_date_pair(date_cmd_t c);
		longint from_serial, diff, off, y, m, d;
		conversion_t r;
		from_serial = day_serial(longint'(c.from_date.year), longint'(c.from_date.month),
			longint'(c.from_date.day));
		diff = day_serial(longint'(c.to_date.year), longint'(c.to_date.month),
			longint'(c.to_date.day)) - from_serial;
		if (diff > DIFF_HI) begin
			diff = DIFF_HI;
		end
		if (diff < DIFF_LO) begin
			diff = DIFF_LO;
		end
		off = longint'(c.offset);
		date_of_serial(from_serial + off, y, m, d);
		r.out_of_range = 1'b0;
		if (y < 0) begin
			y = 0;
			m = 1;
			d = 1;
			r.out_of_range = 1'b1;
		end else if (y > 9999) begin
			y = 9999;
			m = 12;
			d = 31;
			r.out_of_range = 1'b1;
		end
		r.difference = diff[22:0];
		r.year = y[13:0];
		r.month = m[3:0];
		r.day = d[4:0];
		return r;
	endfunction

	function automatic date_cmd_t date_cmd(int fy, int fm, int fd, int ty, int tm, int td,
			int off);
		date_cmd_t c;
		c.from_date.year = 14'(fy);
		c.from_date.month = 4'(fm);
		c.from_date.day = 5'(fd);
		c.to_date.year = 14'(ty);
		c.to_date.month = 4'(tm);
		c.to_date.day = 5'(td);
		c.offset = 23'(off);
		c.drain_first = 1'b0;
		return c;
	endfunction

	// Mostly legal calendar dates; now and then any value the port widths allow.
	function automatic date_t random_date();
		date_t dt;
		if ($urandom_range(0, 9) == 0) begin
			dt.year = 14'($urandom_range(0, 16383));
			dt.month = 4'($urandom_range(0, 15));
			dt.day = 5'($urandom_range(0, 31));
		end else begin
			dt.year = 14'($urandom_range(0, 9999));
			dt.month = 4'($urandom_range(1, 12));
			dt.day = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
				: $urandom_range(1, 28));
		end
		return dt;
	endfunction

	function automatic void flag_failure(string msg);
		if (failures < 10) begin
			$display("%s", msg);
		end
		failures++;
	endfunction

	// Command driver: one beat per handshake, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				conversion_q.push_back(convert_date_pair(driven_cmd));
			end
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (date_cmd_q.size() != 0 &&
						!(date_cmd_q[0].drain_first && conversion_q.size() != 0)) begin
					driven_cmd = date_cmd_q.pop_front();
					from_year <= driven_cmd.from_date.year;
					from_month <= driven_cmd.from_date.month;
					from_day <= driven_cmd.from_date.day;
					to_year <= driven_cmd.to_date.year;
					to_month <= driven_cmd.to_date.month;
					to_day <= driven_cmd.to_date.day;
					offset_days <= driven_cmd.offset;
					start <= 1'b1;
					if (date_cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
						gap_left <= int'($urandom_range(1, 9));
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		conversion_t want;
		if (arst_n && done) begin
			if (conversion_q.size() == 0) begin
				flag_failure("result beat arrived with no command outstanding");
			end else begin
				want = conversion_q.pop_front();
				if (day_difference !== want.difference || shifted_year !== want.year ||
						shifted_month !== want.month || shifted_day !== want.day ||
						shift_out_of_range !== want.out_of_range) begin
					flag_failure($sformatf(
						"mismatch: exp %0d %0d-%0d-%0d %0b, got %0d %0d-%0d-%0d %0b",
						want.difference, want.year, want.month, want.day, want.out_of_range,
						day_difference, shifted_year, shifted_month, shifted_day,
						shift_out_of_range));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_gregorian_date_offset_and_difference_unit failed");
			$finish;
		end
	end

	initial begin : stimulus
		date_cmd_t c;
		int kind;

		// Range ends, clamping on both sides, odd days and months, saturated differences.
		date_cmd_q.push_back(date_cmd(0, 1, 1, 9999, 12, 31, 0));
		date_cmd_q.push_back(date_cmd(9999, 12, 31, 0, 1, 1, 0));
		date_cmd_q.push_back(date_cmd(0, 1, 1, 0, 1, 1, -1));
		date_cmd_q.push_back(date_cmd(9999, 12, 31, 9999, 12, 31, 1));
		date_cmd_q.push_back(date_cmd(0, 1, 1, 1970, 1, 1, 3652424));
		date_cmd_q.push_back(date_cmd(9999, 12, 31, 1970, 1, 1, -3652424));
		date_cmd_q.push_back(date_cmd(5000, 6, 15, 2000, 2, 29, 4194303));
		date_cmd_q.push_back(date_cmd(5000, 6, 15, 1900, 3, 1, -4194304));
		date_cmd_q.push_back(date_cmd(2023, 2, 31, 2023, 3, 3, 0));
		date_cmd_q.push_back(date_cmd(2023, 3, 0, 2023, 2, 28, 0));
		date_cmd_q.push_back(date_cmd(2023, 0, 15, 2022, 12, 15, 10));
		date_cmd_q.push_back(date_cmd(2023, 13, 1, 2024, 1, 1, 0));
		date_cmd_q.push_back(date_cmd(2023, 14, 1, 2024, 2, 1, 0));
		date_cmd_q.push_back(date_cmd(2023, 15, 31, 2024, 4, 1, 0));
		date_cmd_q.push_back(date_cmd(16383, 15, 31, 0, 0, 0, 0));
		date_cmd_q.push_back(date_cmd(0, 0, 0, 16383, 15, 31, 4194303));
		date_cmd_q.push_back(date_cmd(12000, 6, 1, 1, 1, 1, -1000000));
		date_cmd_q.push_back(date_cmd(2000, 2, 29, 2100, 2, 29, 365));
		date_cmd_q.push_back(date_cmd(1900, 2, 29, 1900, 3, 1, -36524));
		date_cmd_q.push_back(date_cmd(0, 3, 1, 0, 2, 29, -60));
		date_cmd_q.push_back(date_cmd(9999, 1, 1, 0, 1, 1, 364));
		date_cmd_q.push_back(date_cmd(1970, 1, 1, 1969, 12, 31, -719468));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			c.from_date = random_date();
			c.to_date = random_date();
			kind = int'($urandom_range(0, 9));
			if (kind < 3) begin
				c.offset = 23'(int'($urandom_range(0, 3000)) - 1500);
			end else if (kind < 6) begin
				c.offset = 23'(int'($urandom_range(0, 7304848)) - 3652424);
			end else if (kind < 8) begin
				c.offset = 23'($urandom());
			end else if (kind == 8) begin
				// Push a date near year 0 just below the range.
				c.from_date.year = 14'($urandom_range(0, 3));
				c.offset = 23'(-int'($urandom_range(0, 3000)));
			end else begin
				c.from_date.year = 14'($urandom_range(9996, 9999));
				c.offset = 23'($urandom_range(0, 3000));
			end
			if (kind == 9 && $urandom_range(0, 1) == 0) begin
				c.to_date = c.from_date;
			end
			// Hold the beat back until everything in flight has come out.
			c.drain_first = (i == 200) || ($urandom_range(0, 199) == 0);
			date_cmd_q.push_back(c);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (date_cmd_q.size() != 0 || start) @(negedge clk);
		while (conversion_q.size() != 0) @(negedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (conversion_q.size() != 0) begin
			flag_failure($sformatf("%0d result beats never arrived", conversion_q.size()));
		end
		if (failures == 0) begin
			$display("tb_gregorian_date_offset_and_difference_unit passed");
		end else begin
			$display("tb_gregorian_date_offset_and_difference_unit failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/gdo_pkg.sv
sv/gdo_day_count.sv
sv/gdo_date_split.sv
sv/gregorian_date_offset_and_difference_unit.sv
sv/gdo_checker.sv
verif/tb_gregorian_date_offset_and_difference_unit.sv
